// ----- sv/dpr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types, byte codes and the hex digit decode of the debug packet
// receiver.
// ----------------------------------------------------------------------------
package dpr_pkg;

   localparam int FIELD_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] NIB_MASK = 8'h4F;
   localparam logic [3:0] NIB_ADJ = 4'd9;

   typedef enum logic [1:0] {
      EV_CMD = 2'd0,
      EV_DIGIT = 2'd1,
      EV_FIELD = 2'd2,
      EV_VERDICT = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_DOLLAR = 2'd1,
      CLS_HASH = 2'd2,
      CLS_SEP = 2'd3
   } class_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] command_byte;
      logic [3:0] digit_value;
      logic [31:0] field_value;
      logic [3:0] field_index;
      logic [5:0] digit_count;
      logic [7:0] field_closer;
      logic checksum_ok;
      logic [7:0] ack_byte;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      class_type cls;
      logic [3:0] nib;
   } token_type;

   function automatic logic [3:0] nib_of(input logic [7:0] c);
      logic [7:0] a;
      a = c & NIB_MASK;
      return a[3:0] + (a[6] ? NIB_ADJ : 4'd0);
   endfunction

endpackage

// ----- sv/dpr_ifs.sv -----
// ----------------------------------------------------------------------------
// dpr_ifs
// Valid/ready channels for received bytes and for receiver events.
// ----------------------------------------------------------------------------
interface dpr_req_if import dpr_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dpr_rsp_if import dpr_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/dpr_front.sv -----
// ----------------------------------------------------------------------------
// dpr_front
// Accepts received bytes and tags each with its class and hex nibble.
// ----------------------------------------------------------------------------
module dpr_front import dpr_pkg::*; (
   dpr_req_if.sink req_chan,
   input logic q_ready,
   output logic q_push,
   output token_type q_token
);

   logic [7:0] c;

   assign c = req_chan.payload.rx_byte;
   assign req_chan.ready = q_ready;
   assign q_push = req_chan.valid & q_ready;

   always_comb begin
      q_token.rx_byte = c;
      q_token.nib = nib_of(c);
      if (c == CH_DOLLAR) begin
         q_token.cls = CLS_DOLLAR;
      end else if (c == CH_HASH) begin
         q_token.cls = CLS_HASH;
      end else if (c == CH_COMMA || c == CH_COLON || c == CH_SEMI) begin
         q_token.cls = CLS_SEP;
      end else begin
         q_token.cls = CLS_OTHER;
      end
   end

endmodule

// ----- sv/dpr_queue.sv -----
// ----------------------------------------------------------------------------
// dpr_queue
// Small token queue between the classifier and the packet state machine.
// ----------------------------------------------------------------------------
module dpr_queue import dpr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input token_type push_token,
   output logic ready,
   input logic pop,
   output logic valid,
   output token_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/dpr_back.sv -----
// ----------------------------------------------------------------------------
// dpr_back
// Packet state machine: framing, running sum, hex fields and checksum
// verdict, with a registered result stage.
// ----------------------------------------------------------------------------
module dpr_back import dpr_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input token_type q_head,
   output logic q_pop,
   dpr_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_HUNT = 3'd0,
      ST_CMD = 3'd1,
      ST_BODY = 3'd2,
      ST_CKHI = 3'd3,
      ST_CKLO = 3'd4
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] sum_ff, sum_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [3:0] index_ff, index_in;
   logic [5:0] digits_ff, digits_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [3:0] hi_ff, hi_in;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic res_valid;
   rsp_payload_type res;
   logic [7:0] c;
   logic closing;
   logic [7:0] rx_sum;

   assign c = q_head.rx_byte;
   assign closing = (q_head.cls == CLS_HASH) || (q_head.cls == CLS_SEP);
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      if (state_ff == ST_CKLO) begin
         rx_sum = closing ? {4'h0, hi_ff} : {hi_ff, q_head.nib};
      end else begin
         rx_sum = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff;
      acc_in = acc_ff;
      index_in = index_ff;
      digits_in = digits_ff;
      cmd_in = cmd_ff;
      hi_in = hi_ff;
      res_valid = 1'b0;
      res = '0;
      res.command_byte = cmd_ff;
      unique case (state_ff)
         ST_CMD: begin
            if (q_head.cls == CLS_HASH) begin
               state_in = ST_CKHI;
            end else begin
               cmd_in = c;
               sum_in = sum_ff + c;
               state_in = ST_BODY;
               res_valid = 1'b1;
               res.event_res = EV_CMD;
               res.command_byte = c;
            end
         end
         ST_BODY: begin
            res_valid = 1'b1;
            res.field_index = index_ff;
            if (closing) begin
               res.event_res = EV_FIELD;
               res.field_value = 32'(acc_ff);
               res.digit_count = digits_ff;
               res.field_closer = c;
               if (q_head.cls == CLS_HASH) begin
                  state_in = ST_CKHI;
               end else begin
                  sum_in = sum_ff + c;
                  acc_in = '0;
                  digits_in = '0;
                  if (index_ff != 4'hF) begin
                     index_in = index_ff + 4'd1;
                  end
               end
            end else begin
               sum_in = sum_ff + c;
               acc_in = {acc_ff[FIELD_BITS-5:0], q_head.nib};
               if (digits_ff != 6'h3F) begin
                  digits_in = digits_ff + 6'd1;
               end
               res.event_res = EV_DIGIT;
               res.digit_value = q_head.nib;
               res.field_value = 32'(acc_in);
               res.digit_count = digits_in;
            end
         end
         ST_CKHI, ST_CKLO: begin
            if (state_ff == ST_CKHI && !closing) begin
               hi_in = q_head.nib;
               state_in = ST_CKLO;
            end else begin
               state_in = ST_HUNT;
               res_valid = 1'b1;
               res.event_res = EV_VERDICT;
               res.checksum_ok = (rx_sum == sum_ff);
               res.ack_byte = (rx_sum == sum_ff) ? CH_PLUS : CH_MINUS;
               res.computed_sum = sum_ff;
               res.received_sum = rx_sum;
            end
         end
         default: begin
            if (q_head.cls == CLS_DOLLAR) begin
               state_in = ST_CMD;
               sum_in = '0;
               acc_in = '0;
               index_in = '0;
               digits_in = '0;
               hi_in = '0;
            end else begin
               state_in = ST_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         sum_ff <= '0;
         acc_ff <= '0;
         index_ff <= '0;
         digits_ff <= '0;
         cmd_ff <= '0;
         hi_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         state_ff <= state_in;
         sum_ff <= sum_in;
         acc_ff <= acc_in;
         index_ff <= index_in;
         digits_ff <= digits_in;
         cmd_ff <= cmd_in;
         hi_ff <= hi_in;
         rsp_valid_ff <= res_valid;
         rsp_ff <= res;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   a_verdict_rehunt: assert property (@(posedge clock) disable iff (reset)
      (q_pop && res_valid && res.event_res == EV_VERDICT) |=> (state_ff == ST_HUNT))
      else $error("state machine did not return to hunting after a verdict");

   a_cmd_to_body: assert property (@(posedge clock) disable iff (reset)
      (q_pop && res_valid && res.event_res == EV_CMD) |=> (state_ff == ST_BODY))
      else $error("command byte did not move to body");

   a_ack_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == EV_VERDICT) |->
      ((rsp_ff.checksum_ok && rsp_ff.ack_byte == CH_PLUS) ||
       (!rsp_ff.checksum_ok && rsp_ff.ack_byte == CH_MINUS)))
      else $error("ack byte disagrees with checksum verdict");

   a_no_stall_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !q_pop)
      else $error("token consumed while result stage is stalled");

endmodule

// ----- sv/debug_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// debug_packet_receiver
// Serial debug packet receiver: framing, hex fields and checksum verdict.
// Path: an accepted byte is written into the queue, then popped into the
// registered result stage when that stage is free.
// Throughput: one byte per cycle unless results stall; queue and result register
// decouple the two sides, and the classifier stalls only when the queue is full.
// Reset empties the queue and result stage and returns to hunting for '$'.
// ----------------------------------------------------------------------------
module debug_packet_receiver import dpr_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   dpr_req_if.sink req_chan,
   dpr_rsp_if.source rsp_chan
);

   logic q_push;
   logic q_ready;
   logic q_pop;
   logic q_valid;
   token_type q_token;
   token_type q_head;

   dpr_front u_front (
      .req_chan(req_chan),
      .q_ready(q_ready),
      .q_push(q_push),
      .q_token(q_token)
   );

   dpr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_token(q_token),
      .ready(q_ready),
      .pop(q_pop),
      .valid(q_valid),
      .head(q_head)
   );

   dpr_back #(
      .FIELD_BITS(FIELD_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

// ----- sim/packet_event_checker.sv -----
// ----------------------------------------------------------------------------
// packet_event_checker
// Watches the byte and event channels of the debug packet receiver, predicts
// the events that accepted bytes cause and compares every accepted event, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module packet_event_checker import dpr_pkg::*; (
   input logic clock,
   input logic reset,
   dpr_req_if req_mon,
   dpr_rsp_if rsp_mon,
   output int failures,
   output int outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      RX_HUNT,
      RX_COMMAND,
      RX_BODY,
      RX_SUM_HIGH,
      RX_SUM_LOW
   } rx_phase_type;

   rx_phase_type rx_phase;
   logic [7:0] frame_sum;
   logic [31:0] field_acc;
   logic [3:0] field_num;
   logic [5:0] digit_num;
   logic [7:0] packet_cmd;
   logic [3:0] sum_high;

   rsp_payload_type pending_events[$];
   rsp_payload_type want;
   rsp_payload_type got;
   int error_count = 0;

   function automatic logic [3:0] decode_nibble(input logic [7:0] c);
      logic [3:0] low;
      logic alpha;
      low = c[3:0];
      alpha = c[6];
      return low + {alpha, 2'b00, alpha};
   endfunction

   function automatic bit is_closer(input logic [7:0] c);
      return (c == CH_HASH) || (c == CH_COMMA) || (c == CH_COLON) || (c == CH_SEMI);
   endfunction

   task automatic close_packet(input logic [7:0] rcv);
      rsp_payload_type ev;
      ev = '0;
      ev.event_res = EV_VERDICT;
      ev.command_byte = packet_cmd;
      ev.checksum_ok = (rcv == frame_sum);
      ev.ack_byte = (rcv == frame_sum) ? CH_PLUS : CH_MINUS;
      ev.computed_sum = frame_sum;
      ev.received_sum = rcv;
      pending_events.push_back(ev);
      rx_phase = RX_HUNT;
   endtask

   task automatic decode_rx_byte(input logic [7:0] c);
      rsp_payload_type ev;
      logic [3:0] nib;
      ev = '0;
      nib = decode_nibble(c);
      case (rx_phase)
         RX_COMMAND: begin
            if (c == CH_HASH) begin
               rx_phase = RX_SUM_HIGH;
            end else begin
               packet_cmd = c;
               frame_sum = frame_sum + c;
               rx_phase = RX_BODY;
               ev.event_res = EV_CMD;
               ev.command_byte = c;
               pending_events.push_back(ev);
            end
         end
         RX_BODY: begin
            ev.command_byte = packet_cmd;
            if (is_closer(c)) begin
               if (c != CH_HASH) frame_sum = frame_sum + c;
               ev.event_res = EV_FIELD;
               ev.field_value = field_acc;
               ev.field_index = field_num;
               ev.digit_count = digit_num;
               ev.field_closer = c;
               pending_events.push_back(ev);
               if (c == CH_HASH) begin
                  rx_phase = RX_SUM_HIGH;
               end else begin
                  field_acc = '0;
                  digit_num = '0;
                  if (field_num != 4'd15) field_num = field_num + 4'd1;
               end
            end else begin
               frame_sum = frame_sum + c;
               field_acc = {field_acc[27:0], nib};
               if (digit_num != 6'd63) digit_num = digit_num + 6'd1;
               ev.event_res = EV_DIGIT;
               ev.digit_value = nib;
               ev.field_value = field_acc;
               ev.field_index = field_num;
               ev.digit_count = digit_num;
               pending_events.push_back(ev);
            end
         end
         RX_SUM_HIGH: begin
            if (is_closer(c)) begin
               close_packet(8'h00);
            end else begin
               sum_high = nib;
               rx_phase = RX_SUM_LOW;
            end
         end
         RX_SUM_LOW: begin
            if (is_closer(c)) close_packet({4'h0, sum_high});
            else close_packet({sum_high, nib});
         end
         default: begin
            if (c == CH_DOLLAR) begin
               rx_phase = RX_COMMAND;
               frame_sum = '0;
               field_acc = '0;
               field_num = '0;
               digit_num = '0;
               sum_high = '0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_phase = RX_HUNT;
         frame_sum = '0;
         field_acc = '0;
         field_num = '0;
         digit_num = '0;
         packet_cmd = '0;
         sum_high = '0;
         pending_events.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) decode_rx_byte(req_mon.payload.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (pending_events.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected event at %0t: got %h", $realtime, got);
            end else begin
               want = pending_events.pop_front();
               if (got.event_res !== want.event_res
                     || got.command_byte !== want.command_byte
                     || got.digit_value !== want.digit_value
                     || got.field_value !== want.field_value
                     || got.field_index !== want.field_index
                     || got.digit_count !== want.digit_count
                     || got.field_closer !== want.field_closer
                     || got.checksum_ok !== want.checksum_ok
                     || got.ack_byte !== want.ack_byte
                     || got.computed_sum !== want.computed_sum
                     || got.received_sum !== want.received_sum) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("event mismatch at %0t: expected %h, got %h",
                        $realtime, want, got);
               end
            end
         end
      end
      outstanding <= pending_events.size();
      failures <= error_count;
   end

endmodule

// ----- sim/tb_debug_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// tb_debug_packet_receiver
// Feeds the debug packet receiver with directed frames (empty packet, odd
// digits, separators inside the checksum) and then random framed packets
// with noise, long fields and bad checksums, under changing idle and stall
// patterns. The checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
module tb_debug_packet_receiver import dpr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_TARGET = 1250;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   int idle_pct = 0;
   int stall_pct = 0;
   int sent = 0;
   int cycles = 0;
   int failures;
   int outstanding;

   dpr_req_if req_if ();
   dpr_rsp_if rsp_if ();

   debug_packet_receiver DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   packet_event_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_if),
      .rsp_mon(rsp_if),
      .failures(failures),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   task automatic put_byte(input logic [7:0] b, input bit counts);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (counts) sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b1);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_packet();
      logic [7:0] sum;
      logic [7:0] c;
      logic [7:0] seps[3];
      int nf;
      int nd;
      int kind;
      seps = '{CH_COMMA, CH_COLON, CH_SEMI};
      sum = '0;
      repeat ($urandom_range(0, 2)) begin
         c = 8'($urandom_range(0, 255));
         if (c == CH_DOLLAR) c = 8'h00;
         put_byte(c, 1'b0);
      end
      put_byte(CH_DOLLAR, 1'b1);
      if ($urandom_range(0, 11) == 0) begin
         put_byte(CH_HASH, 1'b1);
      end else begin
         if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
         else c = 8'($urandom_range(8'h61, 8'h7a));
         if (c == CH_HASH) c = 8'h67;
         put_byte(c, 1'b1);
         sum = sum + c;
         nf = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 4);
         for (int f = 0; f <= nf; f++) begin
            nd = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(0, 10);
            repeat (nd) begin
               if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
               else c = hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
               if (c == CH_HASH) c = 8'h2A;
               put_byte(c, 1'b1);
               sum = sum + c;
            end
            if (f < nf) begin
               c = seps[$urandom_range(0, 2)];
               put_byte(c, 1'b1);
               sum = sum + c;
            end
         end
         put_byte(CH_HASH, 1'b1);
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
         put_byte(hex_digit(sum[7:4], 1'($urandom_range(0, 1))), 1'b1);
         put_byte(hex_digit(sum[3:0], 1'($urandom_range(0, 1))), 1'b1);
      end else if (kind < 18) begin
         put_byte(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b1);
         put_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         if (kind == 19) put_byte(hex_digit(4'($urandom_range(0, 15)), 1'b0), 1'b1);
         c = ($urandom_range(0, 3) == 0) ? CH_HASH : seps[$urandom_range(0, 2)];
         put_byte(c, 1'b1);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // noise while hunting
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      // empty packet with matching checksum
      send_text("$#00");
      // all-ones digit, stray start byte in body, separator as first checksum byte
      send_text("$m");
      put_byte(8'hFF, 1'b1);
      send_text("9a,:$#,");
      // hash as second checksum byte
      send_text("$Gx;#5#");
      drain();

      while (sent < BYTE_TARGET) begin
         case ((sent / 150) % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 68;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 68;
            end
            default: begin
               idle_pct = 21;
               stall_pct = 21;
            end
         endcase
         send_packet();
      end
      stall_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/dpr_pkg.sv
sv/dpr_ifs.sv
sv/dpr_front.sv
sv/dpr_queue.sv
sv/dpr_back.sv
sv/debug_packet_receiver.sv
sim/packet_event_checker.sv
sim/tb_debug_packet_receiver.sv
